// ===== rtl/wnps_pkg.sv =====
// Shared types and constants for the wildcard nibble pattern scanner.
`default_nettype none
package wnps_pkg;

   localparam int ADDR_W    = 48;
   localparam int PAT_W     = 64;
   localparam int PAT_BYTES = 8;
   localparam int MASK_W    = 16;
   localparam int LEN_W     = 4;
   localparam int CSR_IDX_W = 3;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATTERN_VALUE  = 3'd0,
      REG_CARE_MASK      = 3'd1,
      REG_PATTERN_LENGTH = 3'd2,
      REG_SEARCH_START   = 3'd3,
      REG_SEARCH_END     = 3'd4,
      REG_REPORT_ALL     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic out_full;
      logic skid_full;
   } buf_status_type;

endpackage
`default_nettype wire

// ===== rtl/wnps_match.sv =====
// Window compare against the wildcard pattern plus the search range check.
`default_nettype none
module wnps_match
   import wnps_pkg::*;
#(
   parameter int USED_MAX = 8
) (
   input  wire logic [USED_MAX*8-1:0] win_bytes,
   input  wire logic [PAT_W-1:0]      pattern,
   input  wire logic [MASK_W-1:0]     care_mask,
   input  wire logic [LEN_W-1:0]      len_used,
   input  wire addr_type              byte_address,
   input  wire addr_type              search_start,
   input  wire addr_type              search_end,
   output logic                       window_hit,
   output addr_type                   match_address
);

   localparam int WIN_IDX_W = (USED_MAX > 1) ? $clog2(USED_MAX) : 1;

   logic               pattern_ok;
   logic               addr_ok;
   logic               borrow;
   addr_type           first_addr;

   // Window byte len-1-k lines up with pattern byte k (oldest byte first).
   always_comb begin
      logic [LEN_W-1:0]     idx;
      logic [WIN_IDX_W-1:0] win_idx;
      logic [7:0]           seen;
      logic [7:0]           diff;
      pattern_ok = 1'b1;
      for (int k = 0; k < USED_MAX; k++) begin
         idx     = LEN_W'(len_used - LEN_W'(1) - LEN_W'(k));
         win_idx = idx[WIN_IDX_W-1:0];
         seen    = win_bytes[8*win_idx +: 8];
         diff    = seen ^ pattern[8*k +: 8];
         if (LEN_W'(k) < len_used) begin
            if (care_mask[2*k] && (diff[7:4] != 4'h0)) begin
               pattern_ok = 1'b0;
            end
            if (care_mask[2*k+1] && (diff[3:0] != 4'h0)) begin
               pattern_ok = 1'b0;
            end
         end
      end
   end

   // Start of window; a borrow means it would fall below address zero.
   assign {borrow, first_addr} = {1'b0, byte_address}
                               - {1'b0, ADDR_W'(len_used - LEN_W'(1))};

   assign addr_ok = !borrow && (first_addr >= search_start)
                  && (byte_address <= search_end);

   assign window_hit    = pattern_ok && addr_ok;
   assign match_address = first_addr;

endmodule
`default_nettype wire

// ===== rtl/wnps_rsp_buf.sv =====
// Two-entry result buffer: output register plus skid register.
`default_nettype none
module wnps_rsp_buf
   import wnps_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire addr_type push_address,
   output logic          push_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output addr_type      rsp_match_address,
   output buf_status_type status
);

   logic     out_valid_ff, out_valid_in;
   logic     skid_valid_ff, skid_valid_in;
   addr_type out_addr_ff, out_addr_in;
   addr_type skid_addr_ff, skid_addr_in;
   logic     pop;

   assign pop = out_valid_ff && rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_addr_in   = out_addr_ff;
      skid_valid_in = skid_valid_ff;
      skid_addr_in  = skid_addr_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            // advance the skid entry; no push can arrive while skid is full
            out_valid_in  = 1'b1;
            out_addr_in   = skid_addr_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_addr_in  = push_address;
         end
      end else if (push) begin
         // output stalled: park the new result
         skid_valid_in = 1'b1;
         skid_addr_in  = push_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_addr_ff  <= out_addr_in;
      skid_addr_ff <= skid_addr_in;
   end

   assign push_ready        = !skid_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_match_address = out_addr_ff;
   assign status.out_full   = out_valid_ff;
   assign status.skid_full  = skid_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/wildcard_nibble_pattern_scanner_core.sv =====
// Top level of the wildcard nibble pattern scanner.
`default_nettype none
// Scans a byte stream, one byte per transfer, against a pattern of up to eight
// bytes whose nibbles may be wildcards (care mask bit clear). The byte shifts
// into a short history and the window of the last pattern_length bytes is
// compared in the same cycle the byte is taken; a match whose window lies
// fully inside [search_start, search_end] yields one result transfer carrying
// the window's first address. A transfer with scan_begin set restarts the
// scan (history fill and found flag). With report_all clear only the first
// match of each scan is reported. Throughput is one byte per clock: req_ready
// stays high unless both the result register and its skid register hold
// results that rsp_ready has not yet taken. An accepted byte's result is
// registered and presented in the next cycle while the result register is
// free. Configuration writes (csr_ready is always high) must only be issued
// while the scanner is idle.
module wildcard_nibble_pattern_scanner_core
   import wnps_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_data_byte,
   input  wire addr_type             req_byte_address,
   input  wire logic                 req_scan_begin,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output addr_type                  rsp_match_address,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [PAT_W-1:0]     csr_wdata
);

   // Window depth actually compared: bounded by history and pattern register.
   localparam int USED_MAX = (MAX_PATTERN_BYTES < PAT_BYTES) ? MAX_PATTERN_BYTES
                                                             : PAT_BYTES;
   localparam int FILL_W   = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int CMP_W    = (FILL_W > LEN_W) ? FILL_W : LEN_W;

   // Configuration registers
   logic [PAT_W-1:0]  pattern_ff;
   logic [MASK_W-1:0] care_mask_ff;
   logic [LEN_W-1:0]  length_ff;
   addr_type          start_ff;
   addr_type          end_ff;
   logic              report_all_ff;

   // Scan state
   logic [7:0]        history_ff [MAX_PATTERN_BYTES];
   logic [7:0]        history_in [MAX_PATTERN_BYTES];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              found_ff, found_in;

   logic                  accept;
   logic [FILL_W-1:0]     fill_base;
   logic                  found_base;
   logic [LEN_W-1:0]      len_used;
   logic [USED_MAX*8-1:0] win_bytes;
   logic                  window_hit;
   logic                  fill_ok;
   logic                  report;
   addr_type              match_address;
   logic                  push_ready;
   buf_status_type        buf_status;

   assign csr_ready = 1'b1;
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   // Configuration writes; drop writes to unknown indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff    <= '0;
         care_mask_ff  <= '1;
         length_ff     <= LEN_W'(1);
         start_ff      <= '0;
         end_ff        <= '1;
         report_all_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PATTERN_VALUE:  pattern_ff    <= csr_wdata;
            REG_CARE_MASK:      care_mask_ff  <= csr_wdata[MASK_W-1:0];
            REG_PATTERN_LENGTH: length_ff     <= csr_wdata[LEN_W-1:0];
            REG_SEARCH_START:   start_ff      <= csr_wdata[ADDR_W-1:0];
            REG_SEARCH_END:     end_ff        <= csr_wdata[ADDR_W-1:0];
            REG_REPORT_ALL:     report_all_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective length: zero counts as one, clamp to the compared depth.
   always_comb begin
      if (length_ff == '0) begin
         len_used = LEN_W'(1);
      end else if (length_ff > LEN_W'(USED_MAX)) begin
         len_used = LEN_W'(USED_MAX);
      end else begin
         len_used = length_ff;
      end
   end

   // A new scan restarts the fill count and found flag. History bytes past
   // the fill count are never compared, so they need no clearing.
   assign fill_base  = req_scan_begin ? '0 : fill_ff;
   assign found_base = req_scan_begin ? 1'b0 : found_ff;
   assign fill_in    = (fill_base == FILL_W'(MAX_PATTERN_BYTES)) ? fill_base
                                                                 : fill_base + FILL_W'(1);

   // Shift the new byte in; entry 0 is the newest.
   always_comb begin
      history_in[0] = req_data_byte;
      for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
         history_in[i] = history_ff[i-1];
      end
      for (int i = 0; i < USED_MAX; i++) begin
         win_bytes[8*i +: 8] = history_in[i];
      end
   end

   wnps_match #(
      .USED_MAX (USED_MAX)
   ) u_match (
      .win_bytes     (win_bytes),
      .pattern       (pattern_ff),
      .care_mask     (care_mask_ff),
      .len_used      (len_used),
      .byte_address  (req_byte_address),
      .search_start  (start_ff),
      .search_end    (end_ff),
      .window_hit    (window_hit),
      .match_address (match_address)
   );

   assign fill_ok  = CMP_W'(fill_in) >= CMP_W'(len_used);
   assign report   = accept && fill_ok && window_hit && (report_all_ff || !found_base);
   assign found_in = found_base || report;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         found_ff <= 1'b0;
      end else if (accept) begin
         fill_ff  <= fill_in;
         found_ff <= found_in;
      end
      if (accept) begin
         history_ff <= history_in;
      end
   end

   wnps_rsp_buf u_rsp_buf (
      .clock             (clock),
      .reset             (reset),
      .push              (report),
      .push_address      (match_address),
      .push_ready        (push_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_match_address (rsp_match_address),
      .status            (buf_status)
   );

`ifndef SYNTH
   // The skid register only fills behind a stalled output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      buf_status.skid_full |-> buf_status.out_full)
      else $error("skid entry held with empty output register");

   // First-match mode: no second report inside one scan.
   a_single_report: assert property (@(posedge clock) disable iff (reset)
      (accept && found_ff && !req_scan_begin && !report_all_ff) |-> !report)
      else $error("second report within a scan in first-match mode");

   // Fill count saturates at the history depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_PATTERN_BYTES))
      else $error("history fill count out of range");

   // No result presented right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire
